FILE: hw/rtl/hmsr_pkg.sv
package hmsr_pkg;

  // Register file geometry.
  localparam int RF_DEPTH = 32;
  localparam int RF_AW    = 5;
  localparam int RF_DW    = 16;

  // Bus events carried in tuser.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Byte phase within a transfer.
  localparam logic [1:0] PH_POINTER = 2'd0;
  localparam logic [1:0] PH_FIRST   = 2'd1;
  localparam logic [1:0] PH_SECOND  = 2'd2;
  localparam logic [1:0] PH_REFUSE  = 2'd3;

  // Register indexes with special behaviour.
  localparam logic [RF_AW-1:0] REG_CHIP_ID    = 5'd0;
  localparam logic [RF_AW-1:0] REG_REVISION   = 5'd1;
  localparam logic [RF_AW-1:0] REG_INIT       = 5'd3;
  localparam logic [RF_AW-1:0] REG_TEMP       = 5'd4;
  localparam logic [RF_AW-1:0] REG_FAN_LIMIT  = 5'd5;
  localparam logic [RF_AW-1:0] REG_TEMP_LIMIT = 5'd6;
  localparam logic [RF_AW-1:0] REG_FAN_COUNT  = 5'd7;
  localparam logic [RF_AW-1:0] REG_FAN_MIN    = 5'd8;
  localparam logic [RF_AW-1:0] REG_VDD_LIMIT  = 5'd9;
  localparam logic [RF_AW-1:0] REG_VIN2_ALIAS = 5'd10;
  localparam logic [RF_AW-1:0] REG_VIN3_LIMIT = 5'd11;
  localparam logic [RF_AW-1:0] REG_VIN1_LIMIT = 5'd12;
  localparam logic [RF_AW-1:0] REG_VIN3       = 5'd13;
  localparam logic [RF_AW-1:0] REG_MISC       = 5'd15;
  localparam logic [RF_AW-1:0] REG_ALARM_MASK = 5'd17;
  localparam logic [RF_AW-1:0] REG_INT_STATUS = 5'd18;
  localparam logic [RF_AW-1:0] REG_VIN2       = 5'd19;
  localparam logic [RF_AW-1:0] REG_VIN1       = 5'd20;
  localparam logic [RF_AW-1:0] REG_VDD        = 5'd21;

  // Two-byte registers span this range.
  localparam logic [RF_AW-1:0] REG_WORD_FIRST = 5'd7;
  localparam logic [RF_AW-1:0] REG_WORD_LAST  = 5'd12;

  // Write masks.
  localparam logic [RF_DW-1:0] MASK_INIT  = 16'h00fc;
  localparam logic [RF_DW-1:0] MASK_MISC  = 16'h00f8;
  localparam logic [RF_DW-1:0] MASK_ALARM = 16'h007f;
  localparam int               INIT_RESTORE_BIT = 7;

  // Conversion constants.
  localparam int               DIV_NW  = 20;
  localparam int               DIV_DW  = 16;
  localparam int               DIV_CW  = 5;
  localparam logic [DIV_CW-1:0] DIV_STEPS = 5'd20;
  localparam logic [DIV_NW-1:0] FAN_COUNT_CONSTANT = 20'd480000;
  localparam logic [7:0]        TEMP_OFFSET = 8'd119;
  localparam logic [DIV_NW-1:0] VIN_ROUND   = 20'd9;
  localparam logic [DIV_DW-1:0] VIN_DIVISOR = 16'd19;
  localparam logic [DIV_DW-1:0] VDD_DIVISOR = 16'd95;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [DIV_DW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  function automatic logic [RF_DW-1:0] reset_word(input logic [RF_AW-1:0] idx);
    logic [RF_DW-1:0] w;
    unique case (idx)
      REG_CHIP_ID, REG_REVISION:                       w = 16'h0080;
      REG_FAN_LIMIT:                                   w = 16'h00c7;
      REG_TEMP_LIMIT:                                  w = 16'h00c2;
      REG_FAN_MIN:                                     w = 16'h6464;
      REG_VDD_LIMIT, REG_VIN2_ALIAS,
      REG_VIN3_LIMIT, REG_VIN1_LIMIT:                  w = 16'hdac5;
      default:                                         w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/hmsr_div.sv
module hmsr_div
  import hmsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] acc_r, acc_nxt;
  logic [DIV_DW-1:0] den_r, den_nxt;
  logic [DIV_DW:0]   shifted;
  logic              fits;

  // One quotient bit a cycle: the numerator shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  assign shifted = {rem_r, acc_r[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      rem_nxt  = '0;
      acc_nxt  = req.numer;
      den_nxt  = req.denom;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_DW'(shifted - {1'b0, den_r}) : shifted[DIV_DW-1:0];
      acc_nxt = {acc_r[DIV_NW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = acc_r;

endmodule

FILE: hw/rtl/hw_monitor_smbus_registers_core.sv
// Plain events, reads that need no division and fan reads of a stopped fan go from S_PREP
// straight to S_APPLY. Other fan reads and voltage reads pass through the shared 20-step
// restoring divider in S_DIV before S_APPLY. One request is handled at a time; the next is
// taken once the result has been loaded into the output register, which waits until any
// earlier response has been taken. Synchronous active-low reset loads the default register
// words and clears the pointer, the byte phase and the handshake state.
module hw_monitor_smbus_registers_core
  import hmsr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] data_byte, [15:8] temperature, [16] unused, [32:17] fan_a_rpm, [48:33] fan_b_rpm,
  // [61:49] vin1_mv, [74:62] vin2_mv, [87:75] vin3_mv, [100:88] vdd_mv, [103:101] zero
  input  logic [103:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] ack, [8:1] read_byte, [15:9] zero
  output logic [15:0]  out_tdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PREP  = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [RF_DW-1:0] rf_r [RF_DEPTH];
  logic [RF_DW-1:0] rf_nxt [RF_DEPTH];
  logic [RF_AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_data_r, out_data_nxt;
  logic [7:0]       conv_r, conv_nxt;
  logic             fan_mode_r, fan_mode_nxt;
  logic [1:0]       dsel_r, dsel_nxt;

  // Captured request.
  logic [1:0]  op_r;
  logic [7:0]  data_r;
  logic [7:0]  temp_r;
  logic [15:0] fan_a_r, fan_b_r;
  logic [12:0] vin1_r, vin2_r, vin3_r, vdd_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             accept;
  logic [1:0]       phase_eff;
  logic             high_byte;
  logic [15:0]      rpm_sel;
  logic [1:0]       dsel_sel;
  logic [18:0]      rpm_scaled;
  logic [10:0]      fan_scaled;
  logic [7:0]       fan_post, vin_post;
  logic [RF_DW-1:0] rd_val;
  logic [RF_DW-1:0] wr_val;
  logic             wr_en;
  logic             commit;
  logic             ack;
  logic [7:0]       rb;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // A read right after a start behaves as a first-byte read.
  assign phase_eff = (phase_r == PH_POINTER) ? PH_FIRST : phase_r;
  assign high_byte = (phase_eff == PH_FIRST) && (ptr_r >= REG_WORD_FIRST)
                     && (ptr_r <= REG_WORD_LAST);

  assign rpm_sel    = high_byte ? fan_a_r : fan_b_r;
  assign dsel_sel   = high_byte ? rf_r[REG_MISC][7:6] : rf_r[REG_MISC][5:4];
  assign rpm_scaled = {3'b000, rpm_sel} << dsel_sel;

  // Fan result: quotient times the divisor, clamped to 1..255.
  assign fan_scaled = {3'b000, div_rsp.quot[7:0]} << dsel_r;
  always_comb begin
    if (|div_rsp.quot[DIV_NW-1:8] || |fan_scaled[10:8]) begin
      fan_post = 8'hff;
    end else if (fan_scaled[7:0] == 8'h00) begin
      fan_post = 8'h01;
    end else begin
      fan_post = fan_scaled[7:0];
    end
  end
  assign vin_post = |div_rsp.quot[DIV_NW-1:8] ? 8'hff : div_rsp.quot[7:0];

  hmsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Read value of the pointed register; fan and voltage registers use conv_r, temperature adds an offset.
  always_comb begin
    unique case (ptr_r) inside
      REG_TEMP:                     rd_val = {8'h00, 8'(temp_r + TEMP_OFFSET)};
      REG_FAN_COUNT:                rd_val = {conv_r, conv_r};
      REG_VIN3, REG_VIN2, REG_VIN1,
      REG_VDD:                      rd_val = {8'h00, conv_r};
      default:                      rd_val = rf_r[ptr_r];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    phase_nxt     = phase_r;
    conv_nxt      = conv_r;
    fan_mode_nxt  = fan_mode_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rf_nxt        = rf_r;
    div_req.start = 1'b0;
    div_req.numer = '0;
    div_req.denom = '0;
    wr_en         = 1'b0;
    wr_val        = '0;
    commit        = 1'b0;
    ack           = 1'b1;
    rb            = 8'h00;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt    = S_APPLY;
        fan_mode_nxt = 1'b0;
        dsel_nxt     = dsel_sel;
        if (op_r == OP_READ) begin
          unique case (ptr_r) inside
            REG_FAN_COUNT: begin
              fan_mode_nxt = 1'b1;
              if (rpm_sel == 16'h0000) begin
                conv_nxt = 8'h00;
              end else begin
                div_req.start = 1'b1;
                div_req.numer = FAN_COUNT_CONSTANT + DIV_NW'(rpm_scaled[18:1]);
                div_req.denom = rpm_sel;
                state_nxt     = S_DIV;
              end
            end
            REG_VIN3, REG_VIN2, REG_VIN1: begin
              div_req.start = 1'b1;
              div_req.denom = VIN_DIVISOR;
              state_nxt     = S_DIV;
              if (ptr_r == REG_VIN3) begin
                div_req.numer = DIV_NW'(vin3_r) + VIN_ROUND;
              end else if (ptr_r == REG_VIN2) begin
                div_req.numer = DIV_NW'(vin2_r) + VIN_ROUND;
              end else begin
                div_req.numer = DIV_NW'(vin1_r) + VIN_ROUND;
              end
            end
            REG_VDD: begin
              div_req.start = 1'b1;
              div_req.numer = DIV_NW'({vdd_r, 2'b00});
              div_req.denom = VDD_DIVISOR;
              state_nxt     = S_DIV;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          conv_nxt  = fan_mode_r ? fan_post : vin_post;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!out_valid_r || out_tready) begin
          commit    = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_r)
            OP_START: begin
              phase_nxt = PH_POINTER;
            end
            OP_WRITE: begin
              unique case (phase_r)
                PH_POINTER: begin
                  ptr_nxt   = data_r[RF_AW-1:0];
                  phase_nxt = PH_FIRST;
                end
                PH_FIRST: begin
                  wr_en     = 1'b1;
                  wr_val    = {rd_val[15:8], data_r};
                  phase_nxt = PH_SECOND;
                end
                PH_SECOND: begin
                  wr_en     = 1'b1;
                  wr_val    = {rd_val[7:0], data_r};
                  phase_nxt = PH_REFUSE;
                end
                default: begin
                  ack = 1'b0;
                end
              endcase
            end
            OP_READ: begin
              if (high_byte) begin
                phase_nxt = PH_SECOND;
                rb        = rd_val[15:8];
              end else begin
                phase_nxt = phase_eff;
                rb        = rd_val[7:0];
                ptr_nxt   = ptr_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0000000, rb, ack};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en) begin
      unique case (ptr_r) inside
        REG_CHIP_ID, REG_REVISION, REG_TEMP, REG_FAN_COUNT, REG_VIN3,
        REG_INT_STATUS, REG_VIN2, REG_VIN1, REG_VDD: begin
        end
        REG_VIN2_ALIAS: rf_nxt[REG_VIN2] = {8'h00, wr_val[7:0]};
        REG_INIT: begin
          if (wr_val[INIT_RESTORE_BIT]) begin
            for (int i = 0; i < RF_DEPTH; i++) begin
              rf_nxt[i] = reset_word(RF_AW'(i));
            end
          end else begin
            rf_nxt[REG_INIT] = wr_val & MASK_INIT;
          end
        end
        REG_MISC:       rf_nxt[REG_MISC] = wr_val & MASK_MISC;
        REG_ALARM_MASK: rf_nxt[REG_ALARM_MASK] = wr_val & MASK_ALARM;
        default:        rf_nxt[ptr_r] = wr_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      phase_r     <= PH_POINTER;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RF_DEPTH; i++) begin
        rf_r[i] <= reset_word(RF_AW'(i));
      end
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        rf_r <= rf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    conv_r     <= conv_nxt;
    fan_mode_r <= fan_mode_nxt;
    dsel_r     <= dsel_nxt;
    if (accept) begin
      op_r    <= in_tuser;
      data_r  <= in_tdata[7:0];
      temp_r  <= in_tdata[15:8];
      fan_a_r <= in_tdata[32:17];
      fan_b_r <= in_tdata[48:33];
      vin1_r  <= in_tdata[61:49];
      vin2_r  <= in_tdata[74:62];
      vin3_r  <= in_tdata[87:75];
      vdd_r   <= in_tdata[100:88];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
